@@ design/lsg_pkg.sv @@
`default_nettype none

package lsg_pkg;

  // Number format and order range
  localparam int FRAC_BITS = 16;
  localparam int MAX_ORDER = 15;
  localparam int ORDER_W   = 4;
  localparam int VAL_W     = FRAC_BITS + 2;

  // Recurrence datapath widths
  localparam int RND_W     = 2 * FRAC_BITS + 2;
  localparam int NUM_W     = FRAC_BITS + $clog2(3 * MAX_ORDER) + 1;
  localparam int DIV_SH    = NUM_W + $clog2(2 * MAX_ORDER);
  localparam int RECIP_W   = DIV_SH - 1;
  localparam int MUL_A_W   = NUM_W + 1;
  localparam int MUL_B_W   = DIV_SH;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;
  localparam int Q_W       = MUL_W - DIV_SH;

  localparam int unsigned ONE_MAG  = 1 << FRAC_BITS;
  localparam int unsigned HALF_LSB = 1 << (FRAC_BITS - 1);
  localparam logic signed [VAL_W-1:0] ONE_VAL     = VAL_W'(ONE_MAG);
  localparam logic signed [VAL_W-1:0] NEG_ONE_VAL = -ONE_VAL;

  // Configuration register map
  localparam int APB_AW = 3;
  localparam logic REG_POLY_ORDER = 1'b0;
  localparam logic [ORDER_W-1:0] POLY_ORDER_RST = ORDER_W'(4);

  // Reciprocals ceil(2^DIV_SH / (2*d)) for the rounded divide by d = n+1
  localparam longint unsigned K_POW = longint'(1) << DIV_SH;
  localparam logic [RECIP_W-1:0] RECIP_TBL [MAX_ORDER+1] = '{
    RECIP_W'(0),
    RECIP_W'(0),
    RECIP_W'((K_POW + 2*2 - 1) / (2*2)),
    RECIP_W'((K_POW + 2*3 - 1) / (2*3)),
    RECIP_W'((K_POW + 2*4 - 1) / (2*4)),
    RECIP_W'((K_POW + 2*5 - 1) / (2*5)),
    RECIP_W'((K_POW + 2*6 - 1) / (2*6)),
    RECIP_W'((K_POW + 2*7 - 1) / (2*7)),
    RECIP_W'((K_POW + 2*8 - 1) / (2*8)),
    RECIP_W'((K_POW + 2*9 - 1) / (2*9)),
    RECIP_W'((K_POW + 2*10 - 1) / (2*10)),
    RECIP_W'((K_POW + 2*11 - 1) / (2*11)),
    RECIP_W'((K_POW + 2*12 - 1) / (2*12)),
    RECIP_W'((K_POW + 2*13 - 1) / (2*13)),
    RECIP_W'((K_POW + 2*14 - 1) / (2*14)),
    RECIP_W'((K_POW + 2*15 - 1) / (2*15))
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_PROD,
    ST_RND,
    ST_NUM,
    ST_ABS,
    ST_REC,
    ST_FIX
  } state_t;

endpackage

`default_nettype wire

@@ design/legendre_series_generator_core.sv @@
`default_nettype none

// Legendre series generator: for each abscissa x (signed Q1.16, saturated to
// +-1) it produces P0(x) .. P_order(x) in rising degree, one word per degree,
// by Bonnet's recurrence in fixed point with round-to-nearest and +-1 clamp.
// Input: a word is taken at a clock edge with start high and busy low; busy
// stays high until the last word of the run has been shown.
// Output: each word is on out_degree / out_poly_value / out_last_degree for
// one cycle with out_strobe high; the receiver cannot stall, so no result
// is ever held back. out_last_degree marks the word of degree poly_order.
// Timing: P0 appears the cycle after acceptance and P1 the cycle after that.
// Each higher degree goes through one shared 24x28 multiplier (x*P(n), then
// a reciprocal multiply for the divide by n+1) plus rounding, combine and
// sign steps in states PROD, RND, NUM, ABS, REC, FIX. A new word is taken
// only after the run has ended. Configuration: APB register poly_order at
// address 0 (reset 4), to be written only while the block is idle; the
// block itself does not enforce this. Reset (rst_n low, synchronous) returns
// the sequencer to idle and poly_order to 4; no state is kept between words.
module legendre_series_generator_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   start,
  output logic                                  busy,
  input  wire  signed [lsg_pkg::VAL_W-1:0]      in_abscissa,
  // result channel
  output logic                                  out_strobe,
  output logic        [lsg_pkg::ORDER_W-1:0]    out_degree,
  output logic signed [lsg_pkg::VAL_W-1:0]      out_poly_value,
  output logic                                  out_last_degree,
  // configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire         [lsg_pkg::APB_AW-1:0]     paddr,
  input  wire         [31:0]                    pwdata,
  output logic        [31:0]                    prdata,
  output logic                                  pready
);

  import lsg_pkg::*;

  state_t state_r, state_nxt;

  logic [ORDER_W-1:0] poly_order_r, poly_order_nxt;
  logic [ORDER_W-1:0] order_eff;

  logic signed [VAL_W-1:0]   x_r, x_nxt;
  logic signed [VAL_W-1:0]   cur_r, cur_nxt;
  logic signed [VAL_W-1:0]   prev_r, prev_nxt;
  logic signed [VAL_W-1:0]   prod_r, prod_nxt;
  logic        [ORDER_W-1:0] deg_r, deg_nxt;
  logic signed [NUM_W-1:0]   num_r, num_nxt;
  logic        [NUM_W-1:0]   t_r, t_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [MUL_W-1:0]   m_r, m_nxt;

  logic                      accept;
  logic                      is_last;
  logic                      cfg_write;
  logic [ORDER_W-1:0]        div_d;
  logic signed [VAL_W-1:0]   x_sat;

  // shared multiplier
  logic                      mul_sel_prod;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;

  // step results
  logic        [MUL_W-1:0]   m_abs;
  logic        [RND_W-1:0]   rsum;
  logic        [VAL_W-1:0]   rmag;
  logic signed [VAL_W-1:0]   rnd_val;
  logic signed [NUM_W-1:0]   prod_ext, prev_ext, odd_ext, n_ext, num_val;
  logic        [NUM_W-1:0]   num_mag;
  logic        [Q_W-1:0]     quo;
  logic        [VAL_W-1:0]   quo_sat;
  logic signed [VAL_W-1:0]   fix_val;

  // Configuration register
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    poly_order_nxt = poly_order_r;
    if (cfg_write && (paddr[2] == REG_POLY_ORDER)) begin
      poly_order_nxt = pwdata[ORDER_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POLY_ORDER) ? 32'(poly_order_r) : 32'd0;

  // Clamp order to the supported maximum
  assign order_eff = (poly_order_r > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                         : poly_order_r;

  assign accept  = start && (state_r == ST_IDLE);
  assign is_last = (deg_r == order_eff);
  assign div_d   = deg_r + ORDER_W'(1);

  // Saturate the abscissa to +-one
  assign x_sat = (in_abscissa > ONE_VAL)     ? ONE_VAL :
                 (in_abscissa < NEG_ONE_VAL) ? NEG_ONE_VAL : in_abscissa;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (is_last)                    state_nxt = ST_IDLE;
        else if (deg_r == ORDER_W'(0))  state_nxt = ST_EMIT;
        else                            state_nxt = ST_PROD;
      end
      ST_PROD: state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_REC;
      ST_REC:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy         = 1'b1;
    out_strobe   = 1'b0;
    mul_sel_prod = 1'b0;
    mul_en       = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EMIT: out_strobe = 1'b1;
      ST_PROD: begin
        mul_sel_prod = 1'b1;
        mul_en       = 1'b1;
      end
      ST_REC:  mul_en = 1'b1;
      ST_RND, ST_NUM, ST_ABS, ST_FIX: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign out_degree      = deg_r;
  assign out_poly_value  = cur_r;
  assign out_last_degree = is_last;

  // Shared multiplier: x*P(n), or |num|-term times reciprocal of 2(n+1)
  always_comb begin
    if (mul_sel_prod) begin
      mul_a = MUL_A_W'(x_r);
      mul_b = MUL_B_W'(cur_r);
    end else begin
      mul_a = signed'({1'b0, t_r});
      mul_b = signed'({1'b0, RECIP_TBL[div_d]});
    end
  end
  assign mul_p = mul_a * mul_b;
  assign m_nxt = mul_en ? mul_p : m_r;

  // Round the product to FRAC_BITS, ties away from zero
  assign m_abs   = m_r[MUL_W-1] ? MUL_W'(-m_r) : MUL_W'(m_r);
  assign rsum    = m_abs[RND_W-1:0] + RND_W'(HALF_LSB);
  assign rmag    = rsum[RND_W-1:FRAC_BITS];
  assign rnd_val = m_r[MUL_W-1] ? -signed'(rmag) : signed'(rmag);

  // Combine (2n+1)*prod - n*P(n-1)
  assign prod_ext = NUM_W'(prod_r);
  assign prev_ext = NUM_W'(prev_r);
  assign odd_ext  = signed'(NUM_W'({deg_r, 1'b1}));
  assign n_ext    = signed'(NUM_W'(deg_r));
  assign num_val  = odd_ext * prod_ext - n_ext * prev_ext;

  // Magnitude for the rounded divide: floor((2|num| + d) / 2d)
  assign num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);

  // Quotient, clamp to one, restore sign
  assign quo     = m_r[MUL_W-1:DIV_SH];
  assign quo_sat = (quo > Q_W'(ONE_MAG)) ? VAL_W'(ONE_MAG) : quo[VAL_W-1:0];
  assign fix_val = neg_r ? -signed'(quo_sat) : signed'(quo_sat);

  // Datapath register updates
  always_comb begin
    x_nxt    = x_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    prod_nxt = prod_r;
    deg_nxt  = deg_r;
    num_nxt  = num_r;
    t_nxt    = t_r;
    neg_nxt  = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt   = x_sat;
          cur_nxt = ONE_VAL;
          deg_nxt = ORDER_W'(0);
        end
      end
      ST_EMIT: begin
        if (!is_last && (deg_r == ORDER_W'(0))) begin
          prev_nxt = cur_r;
          cur_nxt  = x_r;
          deg_nxt  = ORDER_W'(1);
        end
      end
      ST_RND: prod_nxt = rnd_val;
      ST_NUM: num_nxt = num_val;
      ST_ABS: begin
        t_nxt   = {num_mag[NUM_W-2:0], 1'b0} + NUM_W'(div_d);
        neg_nxt = num_r[NUM_W-1];
      end
      ST_FIX: begin
        prev_nxt = cur_r;
        cur_nxt  = fix_val;
        deg_nxt  = deg_r + ORDER_W'(1);
      end
      ST_PROD, ST_REC: begin
        neg_nxt = neg_r;
      end
      default: neg_nxt = neg_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      poly_order_r <= POLY_ORDER_RST;
    end else begin
      state_r      <= state_nxt;
      poly_order_r <= poly_order_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    prod_r <= prod_nxt;
    deg_r  <= deg_nxt;
    num_r  <= num_nxt;
    t_r    <= t_nxt;
    neg_r  <= neg_nxt;
    m_r    <= m_nxt;
  end

`ifndef SYNTHESIS
  // An accepted word shows P0 = one at degree zero on the next cycle
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe && (out_degree == '0) && (out_poly_value == ONE_VAL)))
    else $error("P0 word missing after accept");

  // The last word of a run frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_degree) |=> !busy)
    else $error("busy after last word");

  // P1 follows P0 directly when the run goes on
  a_p1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_degree && (out_degree == '0))
      |=> (out_strobe && (out_degree == ORDER_W'(1))))
    else $error("P1 word not directly after P0");

  // Words only come out while a run is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result word while idle");
`endif

endmodule

`default_nettype wire
